### sv/event_reuse_token_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef EVENT_REUSE_TOKEN_SCHEDULER_ASSERT_SVH
`define EVENT_REUSE_TOKEN_SCHEDULER_ASSERT_SVH

// Implication checked on every edge outside reset, same cycle.
`define ERTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ERTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

### sv/ertsch_pkg.sv
// Shared types and constants for the event reuse token scheduler.
package ertsch_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int QSUM_W = 8 + CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_REUSE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARALLEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET = 2'd2;

  localparam logic [7:0] REUSE_RESET = 8'd100;
  localparam logic [4:0] PARALLEL_RESET = 5'd1;
  localparam logic [31:0] BUDGET_RESET = 32'hFFFF_FFFF;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NONE = 3'd1;
  localparam logic [2:0] ST_DUP = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic FUNC_OBTAIN = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam int MUL_W = 33;
  localparam int MUL_CNT_W = $clog2(MUL_W + 1);

  typedef enum logic [1:0] {
    TOP_NOP,
    TOP_NEW,
    TOP_SERVE,
    TOP_RELEASE
  } tbl_op_t;

  typedef struct packed {
    tbl_op_t          op;
    logic [IDX_W-1:0] idx;
    logic [31:0]      key_first;
    logic [31:0]      key_second;
    logic [7:0]       reuse;
    logic             tok_orig;
  } tbl_wr_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key_first;
    logic [31:0] key_second;
    logic [7:0]  left_to_serve;
    logic [7:0]  left_to_finish;
    logic        original_done;
  } tbl_entry_t;

endpackage

### sv/ertsch_table.sv
// Entry table: per-entry storage, one read port and one update port.
module ertsch_table
  import ertsch_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_idx,
  output tbl_entry_t       rd_entry,
  input  tbl_wr_t          wr
);

  logic        valid_r [TABLE_ENTRIES];
  logic [31:0] kf_r    [TABLE_ENTRIES];
  logic [31:0] ks_r    [TABLE_ENTRIES];
  logic [7:0]  serve_r [TABLE_ENTRIES];
  logic [7:0]  finish_r[TABLE_ENTRIES];
  logic        done_r  [TABLE_ENTRIES];
  logic [7:0]  reuse_eff;

  assign reuse_eff = (wr.reuse == 8'd0) ? 8'd1 : wr.reuse;

  always_comb begin
    rd_entry.valid          = valid_r[rd_idx];
    rd_entry.key_first      = kf_r[rd_idx];
    rd_entry.key_second     = ks_r[rd_idx];
    rd_entry.left_to_serve  = serve_r[rd_idx];
    rd_entry.left_to_finish = finish_r[rd_idx];
    rd_entry.original_done  = done_r[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) valid_r[i] <= 1'b0;
    end else begin
      case (wr.op)
        TOP_NEW: valid_r[wr.idx] <= 1'b1;
        TOP_RELEASE: begin
          if (finish_r[wr.idx] <= 8'd1) valid_r[wr.idx] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (wr.op)
      TOP_NEW: begin
        kf_r[wr.idx]     <= wr.key_first;
        ks_r[wr.idx]     <= wr.key_second;
        serve_r[wr.idx]  <= reuse_eff - 8'd1;
        finish_r[wr.idx] <= reuse_eff;
        done_r[wr.idx]   <= 1'b0;
      end
      TOP_SERVE: serve_r[wr.idx] <= serve_r[wr.idx] - 8'd1;
      TOP_RELEASE: begin
        if (finish_r[wr.idx] != 8'd0) finish_r[wr.idx] <= finish_r[wr.idx] - 8'd1;
        if (wr.tok_orig) done_r[wr.idx] <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### sv/ertsch_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, result modulo 2^64 plus addend.
module ertsch_mul
  import ertsch_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MUL_W-1:0] mcand,
  input  logic [MUL_W-1:0] mplier,
  input  logic [31:0]      addend,
  output logic             done,
  output logic [63:0]      product
);

  logic                 run_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [63:0]          acc_r;
  logic [63:0]          mcand_r;
  logic [MUL_W-1:0]     mplier_r;
  logic                 done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + MUL_CNT_W'(1);
        if (cnt_r == MUL_CNT_W'(MUL_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= 64'(addend);
      mcand_r  <= 64'(mcand);
      mplier_r <= mplier;
    end else if (run_r) begin
      if (mplier_r[0]) acc_r <= acc_r + mcand_r;
      mcand_r  <= {mcand_r[62:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[MUL_W-1:1]};
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

### sv/event_reuse_token_scheduler.sv
// Event reuse token scheduler: top level with request sequencer and configuration.
// Sequence: an accepted request runs a 16-entry scan, then a decision state, and its result
// is shown, or, when a pairing code is made, a load state and the multiply come first.
// Throughput: one request at a time, in_ready only while idle; a new request is taken only
// after the result has been taken, so output stalls delay the next request.
// Reset (synchronous, active low) empties the table, clears the obtain count, loads defaults.
module event_reuse_token_scheduler
  import ertsch_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [31:0]          in_seed_first,
  input  logic [31:0]          in_seed_second,
  input  logic                 in_token_is_original,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic                 out_is_original,
  output logic [31:0]          out_orig_first,
  output logic [31:0]          out_orig_second,
  output logic                 out_must_wait,
  output logic                 out_entry_freed,
  output logic [63:0]          out_pair_code,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  `include "event_reuse_token_scheduler_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_LOAD,
    S_MULT,
    S_RESP
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [7:0]  reuse_r;
  logic [4:0]  parallel_r;
  logic [31:0] budget_r;

  // Latched request.
  logic        func_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic        tok_r;

  // Scan accumulators and candidates.
  logic [IDX_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  open_r;
  logic [QSUM_W-1:0] queued_r;
  logic              match_found_r;
  logic [IDX_W-1:0]  match_idx_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic              any_found_r;
  logic [IDX_W-1:0]  any_idx_r;
  logic [63:0]       any_key_r;
  logic              done_found_r;
  logic [IDX_W-1:0]  done_idx_r;
  logic [63:0]       done_key_r;
  logic [31:0]       total_r;

  // Result registers.
  logic [2:0]  status_r;
  logic        is_orig_r;
  logic [31:0] oa_r;
  logic [31:0] ob_r;
  logic        wait_r;
  logic        freed_r;
  logic [63:0] code_r;

  tbl_entry_t       rd;
  tbl_wr_t          wr;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] sel_idx;
  logic [63:0]      rd_key;
  logic             key_match;
  logic             can_serve;
  logic             handled;
  logic [32:0]      budget_sum;
  logic             pick_found;
  logic [IDX_W-1:0] pick_idx;
  logic [63:0]      pick_key;

  // Pairing code operands: (s/2)*(s+1) for even s, s*((s+1)/2) for odd s.
  logic [MUL_W-1:0] pair_sum;
  logic [MUL_W-1:0] pair_inc;
  logic [MUL_W-1:0] mul_x;
  logic [MUL_W-1:0] mul_y;
  logic             mul_start;
  logic             mul_done;
  logic [63:0]      mul_product;

  assign rd_key    = {rd.key_first, rd.key_second};
  assign key_match = rd.valid && (rd.key_first == a_r) && (rd.key_second == b_r);
  assign can_serve = rd.valid && (rd.left_to_serve != 8'd0);

  // Budget test: obtain count before this request plus queued reuses, without wrap.
  assign budget_sum = {1'b0, total_r} + 33'(queued_r);
  assign handled = ((32'(open_r) < 32'(parallel_r)) || (queued_r == '0)) &&
                   (budget_sum < {1'b0, budget_r});

  // Reuse pick prefers an entry whose original token has been released.
  assign pick_found = done_found_r || any_found_r;
  assign pick_idx   = done_found_r ? done_idx_r : any_idx_r;
  assign pick_key   = done_found_r ? done_key_r : any_key_r;

  always_comb begin
    if (func_r == FUNC_RELEASE) begin
      sel_idx = match_idx_r;
    end else if (handled) begin
      sel_idx = free_idx_r;
    end else begin
      sel_idx = pick_idx;
    end
  end

  assign rd_idx = (state_r == S_SCAN) ? cnt_r : sel_idx;

  // Table update issued in the decision cycle.
  always_comb begin
    wr.op         = TOP_NOP;
    wr.idx        = sel_idx;
    wr.key_first  = a_r;
    wr.key_second = b_r;
    wr.reuse      = reuse_r;
    wr.tok_orig   = tok_r;
    if (state_r == S_DECIDE) begin
      if (func_r == FUNC_RELEASE) begin
        if (match_found_r) wr.op = TOP_RELEASE;
      end else if (handled) begin
        if (!match_found_r && free_found_r) wr.op = TOP_NEW;
      end else if (pick_found) begin
        wr.op = TOP_SERVE;
      end
    end
  end

  ertsch_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (rd_idx),
    .rd_entry (rd),
    .wr       (wr)
  );

  assign pair_sum  = {1'b0, oa_r} + {1'b0, ob_r};
  assign pair_inc  = pair_sum + MUL_W'(1);
  assign mul_x     = pair_sum[0] ? pair_sum : {1'b0, pair_sum[MUL_W-1:1]};
  assign mul_y     = pair_sum[0] ? {1'b0, pair_inc[MUL_W-1:1]} : pair_inc;
  assign mul_start = (state_r == S_LOAD);

  ertsch_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_x),
    .mplier  (mul_y),
    .addend  (ob_r),
    .done    (mul_done),
    .product (mul_product)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reuse_r    <= REUSE_RESET;
      parallel_r <= PARALLEL_RESET;
      budget_r   <= BUDGET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REUSE_COUNT: reuse_r <= cfg_wdata[7:0];
        REG_PARALLEL:    parallel_r <= cfg_wdata[4:0];
        REG_BUDGET:      budget_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: accept, scan every entry once, decide, optionally compute the
  // pairing code, then hold the result until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r        <= in_func;
            a_r           <= in_seed_first;
            b_r           <= in_seed_second;
            tok_r         <= in_token_is_original;
            cnt_r         <= '0;
            open_r        <= '0;
            queued_r      <= '0;
            match_found_r <= 1'b0;
            match_idx_r   <= '0;
            free_found_r  <= 1'b0;
            free_idx_r    <= '0;
            any_found_r   <= 1'b0;
            any_idx_r     <= '0;
            any_key_r     <= '0;
            done_found_r  <= 1'b0;
            done_idx_r    <= '0;
            done_key_r    <= '0;
            state_r       <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd.valid) begin
            open_r   <= open_r + CNT_W'(1);
            queued_r <= queued_r + QSUM_W'(rd.left_to_serve);
          end
          if (key_match) begin
            match_found_r <= 1'b1;
            match_idx_r   <= cnt_r;
          end
          if (!rd.valid && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= cnt_r;
          end
          if (can_serve && (!any_found_r || rd_key < any_key_r)) begin
            any_found_r <= 1'b1;
            any_idx_r   <= cnt_r;
            any_key_r   <= rd_key;
          end
          if (can_serve && rd.original_done && (!done_found_r || rd_key < done_key_r)) begin
            done_found_r <= 1'b1;
            done_idx_r   <= cnt_r;
            done_key_r   <= rd_key;
          end
          cnt_r <= cnt_r + IDX_W'(1);
          if (cnt_r == LAST_IDX) state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          status_r  <= ST_OK;
          is_orig_r <= 1'b0;
          wait_r    <= 1'b0;
          freed_r   <= 1'b0;
          code_r    <= '0;
          oa_r      <= a_r;
          ob_r      <= b_r;
          state_r   <= S_RESP;
          if (func_r == FUNC_RELEASE) begin
            if (!match_found_r) begin
              status_r <= ST_UNKNOWN;
            end else begin
              freed_r <= (rd.left_to_finish <= 8'd1);
              state_r <= S_LOAD;
            end
          end else begin
            if (total_r != 32'hFFFF_FFFF) total_r <= total_r + 32'd1;
            if (handled) begin
              if (match_found_r) begin
                status_r <= ST_DUP;
              end else if (!free_found_r) begin
                status_r <= ST_FULL;
              end else begin
                is_orig_r <= 1'b1;
                state_r   <= S_LOAD;
              end
            end else if (pick_found) begin
              oa_r    <= pick_key[63:32];
              ob_r    <= pick_key[31:0];
              wait_r  <= !rd.original_done;
              state_r <= S_LOAD;
            end else begin
              status_r <= ST_NONE;
            end
          end
        end
        S_LOAD: state_r <= S_MULT;
        S_MULT: begin
          if (mul_done) begin
            code_r  <= mul_product;
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_RESP);
  assign out_status      = status_r;
  assign out_is_original = is_orig_r;
  assign out_orig_first  = oa_r;
  assign out_orig_second = ob_r;
  assign out_must_wait   = wait_r;
  assign out_entry_freed = freed_r;
  assign out_pair_code   = code_r;

  // The block never takes a new request while a result is pending.
  `ERTS_ASSERT_NOW(a_no_overlap, out_valid, !in_ready)
  // An accepted request always starts a table scan.
  `ERTS_ASSERT_NEXT(a_accept_scans, in_valid && in_ready, state_r == S_SCAN)
  // Error results carry no pairing code.
  `ERTS_ASSERT_NOW(a_err_no_code, out_valid && (out_status != ST_OK), out_pair_code == 64'd0)

endmodule
